// ===== sv/sfe_pkg.sv =====
`default_nettype none
package sfe_pkg;

    localparam int unsigned WordW  = 16;
    localparam int unsigned SbusW  = 11;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned ChanW  = 4;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned ProdW  = 28;
    localparam int unsigned AccW   = SbusW + ByteW;
    // radix-4 divider: two quotient bits per cycle over the 28-bit product
    localparam int unsigned DivSteps = ProdW / 2;

    localparam logic [ChanW-1:0] LastChan   = 4'd15;
    localparam logic [ByteW-1:0] SbusHeader = 8'h0F;
    localparam logic [ByteW-1:0] SbusEnd    = 8'h00;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_IN_MIN   = 3'd0,
        CFG_IN_MAX   = 3'd1,
        CFG_RC_MIN   = 3'd2,
        CFG_RC_MAX   = 3'd3,
        CFG_SBUS_MIN = 3'd4,
        CFG_SBUS_MAX = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [WordW-1:0] channel_word;
        logic             signal_loss;
        logic             fail_safe;
    } sfe_in_t;

    typedef struct packed {
        logic [ByteW-1:0] frame_byte;
        logic             frame_end;
    } sfe_out_t;

    typedef struct packed {
        logic [WordW-1:0] in_min;
        logic [WordW-1:0] in_max;
        logic [WordW-1:0] rc_min;
        logic [WordW-1:0] rc_max;
        logic [SbusW-1:0] sbus_min;
        logic [SbusW-1:0] sbus_max;
    } sfe_cfg_t;

    // one clamped channel waiting for the mapper
    typedef struct packed {
        logic [WordW-1:0] word;
        logic             loss;
        logic             fsafe;
    } sfe_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_HDR  = 3'd1,
        ST_MUL  = 3'd2,
        ST_DIV  = 3'd3,
        ST_FIX  = 3'd4,
        ST_DATA = 3'd5,
        ST_FLAG = 3'd6,
        ST_END  = 3'd7
    } sfe_state_t;

endpackage
`default_nettype wire

// ===== sv/sfe_front.sv =====
`default_nettype none
module sfe_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  sfe_pkg::sfe_in_t     s_payload,
    input  sfe_pkg::sfe_cfg_t    cfg,
    output logic                 q_valid,
    output sfe_pkg::sfe_entry_t  q_entry,
    input  wire                  q_pop
);

    sfe_pkg::sfe_entry_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    logic [sfe_pkg::WordW-1:0] clamped;

    // upper bound is tested first: with crossed bounds, words above in_max get in_max and all others get in_min
    always_comb begin
        if (s_payload.channel_word > cfg.in_max) begin
            clamped = cfg.in_max;
        end else if (s_payload.channel_word < cfg.in_min) begin
            clamped = cfg.in_min;
        end else begin
            clamped = s_payload.channel_word;
        end
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_entry = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= '{word: clamped, loss: s_payload.signal_loss,
                                       fsafe: s_payload.fail_safe};
        end
    end

endmodule
`default_nettype wire

// ===== sv/sfe_back.sv =====
`default_nettype none
module sfe_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  sfe_pkg::sfe_cfg_t    cfg,
    input  wire                  q_valid,
    input  sfe_pkg::sfe_entry_t  q_entry,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire                  m_ready,
    output sfe_pkg::sfe_out_t    m_payload
);

    sfe_pkg::sfe_state_t state_reg, state_next;

    logic [sfe_pkg::ChanW-1:0] ch_reg, ch_next;
    logic [sfe_pkg::ByteW-1:0] pend_reg, pend_next;
    logic [2:0]                pcnt_reg, pcnt_next;
    logic [sfe_pkg::WordW-1:0] word_reg, word_next;
    logic                      loss_reg, loss_next;
    logic                      fs_reg, fs_next;
    logic [sfe_pkg::ProdW-1:0] quo_reg, quo_next;
    logic [sfe_pkg::WordW-1:0] rem_reg, rem_next;
    logic [sfe_pkg::WordW-1:0] dvs_reg, dvs_next;
    logic [3:0]                step_reg, step_next;
    logic                      neg_reg, neg_next;
    logic                      zero_reg, zero_next;
    logic [sfe_pkg::AccW-1:0]  acc_reg, acc_next;
    logic [4:0]                tot_reg, tot_next;
    logic                      m_valid_reg, m_valid_next;
    sfe_pkg::sfe_out_t         m_payload_reg, m_payload_next;

    logic                      out_free;
    logic                      out_load;
    sfe_pkg::sfe_out_t         out_data;

    logic signed [16:0]        diff;
    logic signed [16:0]        span_in;
    logic signed [11:0]        span_out;
    logic [15:0]               diff_mag;
    logic [15:0]               span_in_mag;
    logic [10:0]               span_out_mag;
    logic [sfe_pkg::ProdW-1:0] quo_step;
    logic [15:0]               rem_step;
    logic [16:0]               trial;
    logic [10:0]               q_low;
    logic [10:0]               mapped;
    logic [4:0]                tot_less;

    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // sign-magnitude operands for the map
    always_comb begin
        diff         = $signed({1'b0, word_reg}) - $signed({1'b0, cfg.rc_min});
        span_in      = $signed({1'b0, cfg.rc_max}) - $signed({1'b0, cfg.rc_min});
        span_out     = $signed({1'b0, cfg.sbus_max}) - $signed({1'b0, cfg.sbus_min});
        diff_mag     = diff[16] ? 16'(-diff) : diff[15:0];
        span_in_mag  = span_in[16] ? 16'(-span_in) : span_in[15:0];
        span_out_mag = span_out[11] ? 11'(-span_out) : span_out[10:0];
    end

    // two restoring steps per cycle
    always_comb begin
        quo_step = quo_reg;
        rem_step = rem_reg;
        trial    = '0;
        for (int k = 0; k < 2; k++) begin
            trial    = {rem_step, quo_step[sfe_pkg::ProdW-1]};
            quo_step = {quo_step[sfe_pkg::ProdW-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_step    = 16'(trial - {1'b0, dvs_reg});
                quo_step[0] = 1'b1;
            end else begin
                rem_step = trial[15:0];
            end
        end
    end

    // only the low 11 bits of the quotient reach the wrapped result
    always_comb begin
        q_low    = quo_reg[10:0];
        mapped   = zero_reg ? cfg.sbus_min
                 : ((neg_reg ? 11'(-q_low) : q_low) + cfg.sbus_min);
        tot_less = tot_reg - 5'd8;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sfe_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = (ch_reg == '0) ? sfe_pkg::ST_HDR : sfe_pkg::ST_MUL;
                end
            end
            sfe_pkg::ST_HDR: begin
                if (out_free) begin
                    state_next = sfe_pkg::ST_MUL;
                end
            end
            sfe_pkg::ST_MUL: begin
                state_next = sfe_pkg::ST_DIV;
            end
            sfe_pkg::ST_DIV: begin
                if (step_reg == 4'(sfe_pkg::DivSteps - 1)) begin
                    state_next = sfe_pkg::ST_FIX;
                end
            end
            sfe_pkg::ST_FIX: begin
                state_next = sfe_pkg::ST_DATA;
            end
            sfe_pkg::ST_DATA: begin
                if (out_free && tot_less < 5'd8) begin
                    state_next = (ch_reg == sfe_pkg::LastChan) ? sfe_pkg::ST_FLAG
                                                              : sfe_pkg::ST_IDLE;
                end
            end
            sfe_pkg::ST_FLAG: begin
                if (out_free) begin
                    state_next = sfe_pkg::ST_END;
                end
            end
            sfe_pkg::ST_END: begin
                if (out_free) begin
                    state_next = sfe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sfe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ch_next   = ch_reg;
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        word_next = word_reg;
        loss_next = loss_reg;
        fs_next   = fs_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        acc_next  = acc_reg;
        tot_next  = tot_reg;
        q_pop     = 1'b0;
        out_load  = 1'b0;
        out_data  = '{frame_byte: sfe_pkg::SbusEnd, frame_end: 1'b0};
        case (state_reg)
            sfe_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    word_next = q_entry.word;
                    loss_next = q_entry.loss;
                    fs_next   = q_entry.fsafe;
                end
            end
            sfe_pkg::ST_HDR: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_data  = '{frame_byte: sfe_pkg::SbusHeader, frame_end: 1'b0};
                    pend_next = '0;
                    pcnt_next = '0;
                end
            end
            sfe_pkg::ST_MUL: begin
                quo_next  = sfe_pkg::ProdW'(diff_mag) * sfe_pkg::ProdW'(span_out_mag);
                rem_next  = '0;
                dvs_next  = span_in_mag;
                step_next = '0;
                neg_next  = diff[16] ^ span_out[11] ^ span_in[16];
                zero_next = (span_in == '0);
            end
            sfe_pkg::ST_DIV: begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                step_next = step_reg + 4'd1;
            end
            sfe_pkg::ST_FIX: begin
                acc_next = {sfe_pkg::SbusW'(0), pend_reg}
                         | (sfe_pkg::AccW'(mapped) << pcnt_reg);
                tot_next = {2'b00, pcnt_reg} + 5'(sfe_pkg::SbusW);
            end
            sfe_pkg::ST_DATA: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = '{frame_byte: acc_reg[7:0], frame_end: 1'b0};
                    acc_next = acc_reg >> 8;
                    tot_next = tot_less;
                    if (tot_less < 5'd8) begin
                        pend_next = acc_reg[15:8];
                        pcnt_next = tot_less[2:0];
                        if (ch_reg != sfe_pkg::LastChan) begin
                            ch_next = ch_reg + 4'd1;
                        end
                    end
                end
            end
            sfe_pkg::ST_FLAG: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = '{frame_byte: {4'b0000, fs_reg, loss_reg, 2'b00},
                                 frame_end: 1'b0};
                end
            end
            sfe_pkg::ST_END: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_data  = '{frame_byte: sfe_pkg::SbusEnd, frame_end: 1'b1};
                    ch_next   = '0;
                    pend_next = '0;
                    pcnt_next = '0;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (out_load) begin
            m_valid_next   = 1'b1;
            m_payload_next = out_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sfe_pkg::ST_IDLE;
            ch_reg      <= '0;
            pend_reg    <= '0;
            pcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            pend_reg    <= pend_next;
            pcnt_reg    <= pcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg      <= word_next;
        loss_reg      <= loss_next;
        fs_reg        <= fs_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        step_reg      <= step_next;
        neg_reg       <= neg_next;
        zero_reg      <= zero_next;
        acc_reg       <= acc_next;
        tot_reg       <= tot_next;
        m_payload_reg <= m_payload_next;
    end

endmodule
`default_nettype wire

// ===== sv/sbus_frame_encoder.sv =====
`default_nettype none
// SBUS frame encoder. Sixteen channel words per frame come in on the s_ channel; each is
// clamped to [in_min, in_max], mapped linearly from [rc_min, rc_max] onto
// [sbus_min, sbus_max] (truncated toward zero, wrapped to 11 bits), packed LSB-first, and
// the frame bytes leave on the m_ channel: header 0x0F, 22 data bytes, the flag byte
// (signal loss in bit 2, failsafe in bit 3, taken from the sixteenth channel) and the end
// byte 0x00 flagged by frame_end. A two-entry queue holds clamped words while the mapper
// works. In the back end each channel is popped from the queue, multiplied, divided by the
// radix-4 divider that does the 28-bit division, placed in the bit packer and sent out as
// one to four bytes (counting header, flag and end bytes); a new channel is popped only
// after the last one's bytes are loaded. When the output is not stalled the divider sets
// the rate. Configuration writes take effect at once and belong between frames or while the
// block is idle.
module sbus_frame_encoder (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  sfe_pkg::sfe_in_t             s_payload,
    output logic                         m_valid,
    input  wire                          m_ready,
    output sfe_pkg::sfe_out_t            m_payload,
    input  wire                          cfg_we,
    input  wire [sfe_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire [sfe_pkg::WordW-1:0]     cfg_wdata
);

    sfe_pkg::sfe_cfg_t   cfg_reg, cfg_next;
    logic                q_valid;
    logic                q_pop;
    sfe_pkg::sfe_entry_t q_entry;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (sfe_pkg::cfg_idx_t'(cfg_index))
                sfe_pkg::CFG_IN_MIN:   cfg_next.in_min   = cfg_wdata;
                sfe_pkg::CFG_IN_MAX:   cfg_next.in_max   = cfg_wdata;
                sfe_pkg::CFG_RC_MIN:   cfg_next.rc_min   = cfg_wdata;
                sfe_pkg::CFG_RC_MAX:   cfg_next.rc_max   = cfg_wdata;
                sfe_pkg::CFG_SBUS_MIN: cfg_next.sbus_min = cfg_wdata[sfe_pkg::SbusW-1:0];
                sfe_pkg::CFG_SBUS_MAX: cfg_next.sbus_max = cfg_wdata[sfe_pkg::SbusW-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{in_min: 16'd1000, in_max: 16'd2000, rc_min: 16'd1000,
                         rc_max: 16'd2000, sbus_min: 11'd173, sbus_max: 11'd1811};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sfe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop)
    );

    sfe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // the end byte is always zero
    a_end_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.frame_end |-> m_payload.frame_byte == sfe_pkg::SbusEnd)
        else $error("end marker on a nonzero byte");

    // after the end byte transfers, the next byte cannot also close a frame
    a_no_double_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_payload.frame_end |=> !(m_valid && m_payload.frame_end))
        else $error("two end bytes in a row");

    // a pop only happens with a queued word
    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule
`default_nettype wire

// ===== tb/sbus_frame_encoder_test.sv =====
`timescale 1ns / 1ps

import sfe_pkg::*;

// Tracks the frame the encoder should be building and the bytes still owed on m_.
class frame_byte_tracker;
    logic [WordW-1:0] in_lo;
    logic [WordW-1:0] in_hi;
    logic [WordW-1:0] src_lo;
    logic [WordW-1:0] src_hi;
    logic [SbusW-1:0] tgt_lo;
    logic [SbusW-1:0] tgt_hi;

    logic [ChanW-1:0] chan;
    logic [ByteW-1:0] spill_bits;
    int unsigned      spill_count;

    sfe_out_t         expected_bytes[$];
    int unsigned      error_count;
    int unsigned      checked;

    function new();
        in_lo       = 16'd1000;
        in_hi       = 16'd2000;
        src_lo      = 16'd1000;
        src_hi      = 16'd2000;
        tgt_lo      = 11'd173;
        tgt_hi      = 11'd1811;
        chan        = '0;
        spill_bits  = '0;
        spill_count = 0;
        error_count = 0;
        checked     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
        case (idx)
            CFG_IN_MIN:   in_lo = data;
            CFG_IN_MAX:   in_hi = data;
            CFG_RC_MIN:   src_lo = data;
            CFG_RC_MAX:   src_hi = data;
            CFG_SBUS_MIN: tgt_lo = data[SbusW-1:0];
            CFG_SBUS_MAX: tgt_hi = data[SbusW-1:0];
            default: ;
        endcase
    endfunction

    // clamp, then linear map with truncation toward zero, wrapped to 11 bits
    function logic [SbusW-1:0] scale(logic [WordW-1:0] raw);
        logic [WordW-1:0] w;
        longint           span_src;
        longint           span_tgt;
        longint           r;
        w = raw;
        // upper bound is tested first, which matters when the bounds cross
        if (raw > in_hi) begin
            w = in_hi;
        end else if (raw < in_lo) begin
            w = in_lo;
        end
        span_src = longint'({48'd0, src_hi}) - longint'({48'd0, src_lo});
        span_tgt = longint'({53'd0, tgt_hi}) - longint'({53'd0, tgt_lo});
        if (span_src == 0) begin
            return tgt_lo;
        end
        r = (longint'({48'd0, w}) - longint'({48'd0, src_lo})) * span_tgt / span_src
            + longint'({53'd0, tgt_lo});
        return r[SbusW-1:0];
    endfunction

    function void queue_byte(logic [ByteW-1:0] b, logic closing);
        sfe_out_t o;
        o.frame_byte = b;
        o.frame_end  = closing;
        expected_bytes.push_back(o);
    endfunction

    function void predict_channel(sfe_in_t item);
        logic [AccW-1:0] acc;
        int unsigned     nbits;
        if (chan == '0) begin
            spill_bits  = '0;
            spill_count = 0;
            queue_byte(SbusHeader, 1'b0);
        end
        acc   = AccW'(spill_bits) | (AccW'(scale(item.channel_word)) << spill_count);
        nbits = spill_count + SbusW;
        while (nbits >= ByteW) begin
            queue_byte(acc[ByteW-1:0], 1'b0);
            acc   = acc >> ByteW;
            nbits = nbits - ByteW;
        end
        spill_bits  = acc[ByteW-1:0];
        spill_count = nbits;
        if (chan == LastChan) begin
            // flag byte: signal loss in bit 2, failsafe in bit 3
            queue_byte({4'b0000, item.fail_safe, item.signal_loss, 2'b00}, 1'b0);
            queue_byte(SbusEnd, 1'b1);
            chan        = '0;
            spill_bits  = '0;
            spill_count = 0;
        end else begin
            chan = chan + 1'b1;
        end
    endfunction

    task report(string what);
        $display("sbus_frame_encoder_test: mismatch at byte %0d: %s", checked, what);
        error_count++;
    endtask

    task check_byte(sfe_out_t got);
        sfe_out_t want;
        if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected transfer byte=%h end=%b",
                             got.frame_byte, got.frame_end));
            checked++;
            return;
        end
        want = expected_bytes.pop_front();
        if (got.frame_byte !== want.frame_byte) begin
            report($sformatf("frame_byte got %h want %h", got.frame_byte, want.frame_byte));
        end
        if (got.frame_end !== want.frame_end) begin
            report($sformatf("frame_end got %b want %b", got.frame_end, want.frame_end));
        end
        checked++;
    endtask
endclass

module sbus_frame_encoder_test;

    // indexes past the register list; writes there must be ignored
    localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 3'd7;

    typedef enum int {
        SET_DEFAULT,
        SET_FULL,
        SET_EQUAL_SRC,
        SET_CROSSED,
        SET_REVERSED,
        SET_RANDOM
    } setting_e;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    sfe_in_t              s_payload = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    sfe_out_t             m_payload;
    logic                 cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [WordW-1:0]     cfg_wdata = '0;

    bit                   quiet = 1'b0;
    frame_byte_tracker    frames = new();

    sbus_frame_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("sbus_frame_encoder_test: done, errors");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            frames.check_byte(m_payload);
        end
    end

    // receiver: stall bursts between runs of ready
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    task automatic send_channel(sfe_in_t item);
        s_payload <= item;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        frames.predict_channel(item);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        frames.write_reg(idx, data);
    endtask

    // wait until every owed byte is out, plus a little slack
    task automatic drain();
        s_valid <= 1'b0;
        while (frames.expected_bytes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        logic [WordW-1:0] probe_words [16];
        sfe_in_t          item;
        setting_e         mode;
        logic [WordW-1:0] lo_in;
        logic [WordW-1:0] hi_in;
        logic [WordW-1:0] lo_src;
        logic [WordW-1:0] hi_src;
        logic [SbusW-1:0] lo_tgt;
        logic [SbusW-1:0] hi_tgt;
        int unsigned      phase;
        int unsigned      phase_len;
        int unsigned      random_sent;

        probe_words = '{16'd0, 16'hFFFF, 16'd999, 16'd1000, 16'd1001, 16'd1499,
                        16'd1500, 16'd1501, 16'd1999, 16'd2000, 16'd2001, 16'h8000,
                        16'h7FFF, 16'h5555, 16'hAAAA, 16'd1750};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one full frame at reset settings; flags also set on channels that ignore them
        for (int i = 0; i < 16; i++) begin
            item.channel_word = probe_words[i];
            item.signal_loss  = (i % 2 == 1);
            item.fail_safe    = (i % 3 == 0);
            send_channel(item);
        end

        phase       = 0;
        random_sent = 0;
        while (random_sent < 250) begin
            drain();
            if (phase < 5) begin
                mode = setting_e'((phase + 1) % 5);
            end else if ($urandom_range(0, 1) == 1) begin
                mode = SET_RANDOM;
            end else begin
                mode = setting_e'($urandom_range(0, 4));
            end

            case (mode)
                SET_FULL: begin
                    lo_in = 16'd0;  hi_in = 16'hFFFF;
                    lo_src = 16'd0; hi_src = 16'hFFFF;
                    lo_tgt = 11'd0; hi_tgt = 11'h7FF;
                end
                SET_EQUAL_SRC: begin
                    lo_in  = 16'($urandom_range(0, 32767));
                    hi_in  = lo_in + 16'($urandom_range(0, 32768));
                    lo_src = 16'($urandom);
                    hi_src = lo_src;
                    lo_tgt = 11'($urandom);
                    hi_tgt = 11'($urandom);
                end
                SET_CROSSED: begin
                    lo_in  = 16'($urandom_range(32768, 65535));
                    hi_in  = 16'($urandom_range(0, 32767));
                    lo_src = hi_in;
                    hi_src = lo_in;
                    lo_tgt = 11'd173;
                    hi_tgt = 11'd1811;
                end
                SET_REVERSED: begin
                    lo_in  = 16'd0;    hi_in  = 16'hFFFF;
                    lo_src = 16'hFFFF; hi_src = 16'd0;
                    lo_tgt = 11'h7FF;  hi_tgt = 11'd0;
                end
                SET_RANDOM: begin
                    if ($urandom_range(0, 1) == 1) begin
                        lo_in  = 16'($urandom);
                        hi_in  = 16'($urandom);
                        lo_src = 16'($urandom);
                        hi_src = 16'($urandom);
                        lo_tgt = 11'($urandom);
                        hi_tgt = 11'($urandom);
                    end else begin
                        lo_in  = 16'($urandom_range(0, 30000));
                        hi_in  = lo_in + 16'($urandom_range(0, 30000));
                        lo_src = 16'($urandom_range(0, 30000));
                        hi_src = lo_src + 16'($urandom_range(1, 30000));
                        lo_tgt = 11'($urandom_range(0, 1000));
                        hi_tgt = lo_tgt + 11'($urandom_range(0, 1047));
                    end
                end
                default: begin
                    lo_in  = 16'd1000; hi_in  = 16'd2000;
                    lo_src = 16'd1000; hi_src = 16'd2000;
                    lo_tgt = 11'd173;  hi_tgt = 11'd1811;
                end
            endcase

            write_reg(CFG_IN_MIN, lo_in);
            write_reg(CFG_IN_MAX, hi_in);
            write_reg(CFG_RC_MIN, lo_src);
            write_reg(CFG_RC_MAX, hi_src);
            // upper bits of the 11-bit registers get junk that must be dropped
            write_reg(CFG_SBUS_MIN, {5'($urandom), lo_tgt});
            write_reg(CFG_SBUS_MAX, {5'($urandom), hi_tgt});
            if (phase == 0 || $urandom_range(0, 2) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
            end
            cfg_we <= 1'b0;

            // phase lengths vary from 6 to 40 channels, so writes also land mid-frame
            phase_len = $urandom_range(6, 40);
            repeat (phase_len) begin
                case ($urandom_range(0, 5))
                    0, 1: item.channel_word = 16'($urandom);
                    2: item.channel_word = ($urandom_range(0, 1) ? frames.in_lo : frames.src_lo)
                                           + 16'($urandom_range(0, 4)) - 16'd2;
                    3: item.channel_word = ($urandom_range(0, 1) ? frames.in_hi : frames.src_hi)
                                           + 16'($urandom_range(0, 4)) - 16'd2;
                    4: item.channel_word = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: begin
                        if (frames.in_lo <= frames.in_hi) begin
                            item.channel_word = 16'($urandom_range(frames.in_lo, frames.in_hi));
                        end else begin
                            item.channel_word = 16'($urandom);
                        end
                    end
                endcase
                item.signal_loss = 1'($urandom);
                item.fail_safe   = 1'($urandom);
                send_channel(item);
            end
            random_sent += phase_len;
            phase++;
            if (random_sent >= 200) begin
                quiet = 1'b1;
            end
        end

        drain();
        repeat (50) @(posedge aclk);
        if (frames.error_count == 0 && frames.expected_bytes.size() == 0) begin
            $display("sbus_frame_encoder_test: done, clean");
        end else begin
            $display("sbus_frame_encoder_test: done, errors");
        end
        $finish;
    end

endmodule
